/* design/kdde_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad debounce digit entry package
// Shared widths, key tables, the result record and the key lookup function.
// ----------------------------------------------------------------------------
`default_nettype none

package kdde_pkg;

  localparam int unsigned BUFFER_DEPTH = 15;
  localparam int unsigned COUNT_W      = $clog2(BUFFER_DEPTH + 1);

  localparam int unsigned COLS_W  = 3;
  localparam int unsigned ROWS    = 4;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned COL_SH  = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OUT_W   = 4;

  localparam int unsigned TABLE_SIZE = 12;
  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);

  // Table slot of the '*' key, which empties the buffer
  localparam logic [SLOT_W-1:0] STAR_SLOT = SLOT_W'(10);

  localparam logic [CODE_W-1:0] CODE_TABLE [TABLE_SIZE] = '{
    10'h108, 10'h081, 10'h101, 10'h201,
    10'h082, 10'h102, 10'h202, 10'h084,
    10'h104, 10'h204, 10'h088, 10'h208
  };

  localparam logic [CHAR_W-1:0] CHAR_TABLE [TABLE_SIZE] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
    8'h36, 8'h37, 8'h38, 8'h39, 8'h2A, 8'h23
  };

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } kdde_hit_t;

  typedef struct packed {
    logic [1:0]        state;
    logic              confirmed;
    logic [CHAR_W-1:0] key_char;
    logic              cleared;
    logic              written;
    logic [OUT_W-1:0]  position;
    logic [OUT_W-1:0]  count;
  } kdde_result_t;

  // First table entry that equals the code
  function automatic kdde_hit_t key_lookup(input logic [CODE_W-1:0] code);
    kdde_hit_t res;
    res = '0;
    for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
      if (CODE_TABLE[k] == code) begin
        res.hit  = 1'b1;
        res.slot = SLOT_W'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/kdde_code_form.sv */
// ----------------------------------------------------------------------------
// Keypad key code former
// Picks the first row with any column set and builds its 10-bit key code.
// ----------------------------------------------------------------------------
`default_nettype none

module kdde_code_form (
  input  wire logic [kdde_pkg::COLS_W-1:0] row1_i,
  input  wire logic [kdde_pkg::COLS_W-1:0] row2_i,
  input  wire logic [kdde_pkg::COLS_W-1:0] row3_i,
  input  wire logic [kdde_pkg::COLS_W-1:0] row4_i,
  output logic      [kdde_pkg::CODE_W-1:0] code_o
);

  logic [kdde_pkg::COLS_W-1:0] cols;
  logic [kdde_pkg::ROWS-1:0]   row_hot;

  always_comb begin
    priority if (row1_i != '0) begin
      cols    = row1_i;
      row_hot = 4'b0001;
    end else if (row2_i != '0) begin
      cols    = row2_i;
      row_hot = 4'b0010;
    end else if (row3_i != '0) begin
      cols    = row3_i;
      row_hot = 4'b0100;
    end else if (row4_i != '0) begin
      cols    = row4_i;
      row_hot = 4'b1000;
    end else begin
      cols    = '0;
      row_hot = '0;
    end
  end

  assign code_o = (kdde_pkg::CODE_W'(cols) << kdde_pkg::COL_SH)
                | kdde_pkg::CODE_W'(row_hot);

endmodule

`default_nettype wire

/* design/kdde_entry.sv */
// ----------------------------------------------------------------------------
// Keypad debounce and digit entry
// Debounce state machine, key lookup and digit count for one scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kdde_entry (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [kdde_pkg::CODE_W-1:0] code_i,
  output kdde_pkg::kdde_result_t           result_o
);

  typedef enum logic [1:0] {
    ST_RELEASED       = 2'd0,
    ST_MAYBE_PRESSED  = 2'd1,
    ST_STILL_PRESSED  = 2'd2,
    ST_MAYBE_RELEASED = 2'd3
  } press_state_e;

  press_state_e                 state_q, state_d;
  logic [kdde_pkg::CODE_W-1:0]  held_q, held_d;
  logic [kdde_pkg::COUNT_W-1:0] count_q, count_d;
  kdde_pkg::kdde_hit_t          hit;

  assign hit = kdde_pkg::key_lookup(held_q);

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    count_d  = count_q;
    result_o = '0;
    unique case (state_q)
      ST_RELEASED: begin
        if (code_i != '0) begin
          state_d = ST_MAYBE_PRESSED;
          held_d  = code_i;
        end
      end
      ST_MAYBE_PRESSED: begin
        if (code_i == held_q) begin
          state_d            = ST_STILL_PRESSED;
          result_o.confirmed = 1'b1;
          if (hit.hit) begin
            result_o.key_char = kdde_pkg::CHAR_TABLE[hit.slot];
            if (hit.slot == kdde_pkg::STAR_SLOT) begin
              count_d          = '0;
              result_o.cleared = 1'b1;
            end else if (count_q < kdde_pkg::COUNT_W'(kdde_pkg::BUFFER_DEPTH)) begin
              result_o.position = kdde_pkg::OUT_W'(count_q);
              result_o.written  = 1'b1;
              count_d           = count_q + 1'b1;
            end
          end
        end else begin
          state_d = ST_RELEASED;
        end
      end
      ST_STILL_PRESSED: begin
        if (code_i == '0) begin
          state_d = ST_MAYBE_RELEASED;
        end
      end
      ST_MAYBE_RELEASED: begin
        state_d = (code_i != '0) ? ST_STILL_PRESSED : ST_RELEASED;
      end
      default: begin
        state_d = ST_RELEASED;
      end
    endcase
    result_o.state = state_d;
    result_o.count = kdde_pkg::OUT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RELEASED;
      held_q  <= '0;
      count_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

/* design/keypad_debounce_digit_entry_core.sv */
// ----------------------------------------------------------------------------
// Keypad debounce digit entry core
// Scans one keypad tick per request, debounces the key code and counts the
// digits entered, with '*' emptying the digit buffer.
// ----------------------------------------------------------------------------
//
//   Channel   Valid        Stall        Payload
//   -------   ----------   ----------   --------------------------------------
//   input     in_valid_i   in_stall_o   row1..row4 column bits, 3 bits each
//   output    out_valid_o  out_stall_i  debounce state, key, buffer status
//
// One request per cycle while no result stall holds the input register; each
// request gives exactly one result, which passes the input register and then
// the result register before it is offered.
// Throughput is set by the single pass between the two registers: code
// forming, the 12-entry table compare and the count increment.
// Reset clears the debounce state, the held code and the digit count.
// A stalled result holds the result register, which in turn stalls the
// input register; the input side stalls only when both stages are full and
// the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_digit_entry_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [kdde_pkg::COLS_W-1:0] row1_columns_i,
  input  wire logic [kdde_pkg::COLS_W-1:0] row2_columns_i,
  input  wire logic [kdde_pkg::COLS_W-1:0] row3_columns_i,
  input  wire logic [kdde_pkg::COLS_W-1:0] row4_columns_i,

  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       debounce_state_o,
  output logic                             key_confirmed_o,
  output logic [kdde_pkg::CHAR_W-1:0]      key_char_o,
  output logic                             buffer_cleared_o,
  output logic                             digit_written_o,
  output logic [kdde_pkg::OUT_W-1:0]       write_position_o,
  output logic [kdde_pkg::OUT_W-1:0]       digit_count_o
);

  // Input register stage
  logic                        in_valid_q;
  logic [kdde_pkg::COLS_W-1:0] row1_q, row2_q, row3_q, row4_q;

  // Result register stage
  logic                   out_valid_q;
  kdde_pkg::kdde_result_t res_q;

  logic                        advance;
  logic                        load_in;
  logic                        step;
  logic [kdde_pkg::CODE_W-1:0] code;
  kdde_pkg::kdde_result_t      res_d;

  // Advance the result stage when it is empty or its request is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;
  // Commit the state update only when the tick moves into the result stage
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      row1_q <= row1_columns_i;
      row2_q <= row2_columns_i;
      row3_q <= row3_columns_i;
      row4_q <= row4_columns_i;
    end
  end

  kdde_code_form u_code_form (
    .row1_i (row1_q),
    .row2_i (row2_q),
    .row3_i (row3_q),
    .row4_i (row4_q),
    .code_o (code)
  );

  kdde_entry u_entry (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .code_i   (code),
    .result_o (res_d)
  );

  // Hold the result while stalled, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign debounce_state_o = res_q.state;
  assign key_confirmed_o  = res_q.confirmed;
  assign key_char_o       = res_q.key_char;
  assign buffer_cleared_o = res_q.cleared;
  assign digit_written_o  = res_q.written;
  assign write_position_o = res_q.position;
  assign digit_count_o    = res_q.count;

endmodule

`default_nettype wire

/* dv/keypad_debounce_digit_entry_core_test.sv */
// ----------------------------------------------------------------------------
// Keypad debounce digit entry core testbench
// Drives scan ticks into the core under random idling and stalls, forecasts
// every result with an in-bench debounce and digit-buffer model, and checks
// each result field by field against the oldest forecast.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_digit_entry_core_test;

  import kdde_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned ITEM_TARGET  = 1300;
  localparam int unsigned IDLE_PERCENT = 17;
  localparam int unsigned PRINT_LIMIT  = 40;

  // Row 1 sits in index 0, row 4 in index 3
  typedef logic [ROWS-1:0][COLS_W-1:0] scan_t;

  typedef enum logic [1:0] {
    DB_RELEASED,
    DB_MAYBE_PRESSED,
    DB_STILL_PRESSED,
    DB_MAYBE_RELEASED
  } db_state_e;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [COLS_W-1:0]      row1_columns_i = '0;
  logic [COLS_W-1:0]      row2_columns_i = '0;
  logic [COLS_W-1:0]      row3_columns_i = '0;
  logic [COLS_W-1:0]      row4_columns_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic [1:0]             debounce_state_o;
  logic                   key_confirmed_o;
  logic [CHAR_W-1:0]      key_char_o;
  logic                   buffer_cleared_o;
  logic                   digit_written_o;
  logic [OUT_W-1:0]       write_position_o;
  logic [OUT_W-1:0]       digit_count_o;

  // Forecast state of the keypad: debounce phase, latched code, digits held
  db_state_e              db_state     = DB_RELEASED;
  logic [CODE_W-1:0]      latched_code = '0;
  logic [COUNT_W-1:0]     held_digits  = '0;

  kdde_result_t           awaited_results [$];
  int unsigned            mismatch_count = 0;
  int unsigned            scans_sent     = 0;
  int unsigned            cycle_count    = 0;

  // Idling switches, and a hold-off request handed to the receiver process
  bit                     sender_idles   = 1'b1;
  bit                     receiver_idles = 1'b1;
  int unsigned            hold_off_len   = 0;
  int unsigned            hold_off_seq   = 0;
  int unsigned            hold_off_seen  = 0;
  int unsigned            hold_off_left  = 0;

  keypad_debounce_digit_entry_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .row1_columns_i   (row1_columns_i),
    .row2_columns_i   (row2_columns_i),
    .row3_columns_i   (row3_columns_i),
    .row4_columns_i   (row4_columns_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .debounce_state_o (debounce_state_o),
    .key_confirmed_o  (key_confirmed_o),
    .key_char_o       (key_char_o),
    .buffer_cleared_o (buffer_cleared_o),
    .digit_written_o  (digit_written_o),
    .write_position_o (write_position_o),
    .digit_count_o    (digit_count_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Abort the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keypad_debounce_digit_entry_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Forecast model
  // --------------------------------------------------------------------------

  // Advance the debounce machine and digit buffer by one scan tick
  function automatic kdde_result_t step_keypad(input scan_t s);
    kdde_result_t      r;
    logic [CODE_W-1:0] code;
    bit                matched;
    code    = '0;
    matched = 1'b0;
    r       = '0;
    // Walk the rows from last to first so the first active row wins
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (s[i] != '0) begin
        code = (CODE_W'(s[i]) << COL_SH) | CODE_W'(1 << i);
      end
    end
    case (db_state)
      DB_RELEASED: begin
        if (code != '0) begin
          db_state     = DB_MAYBE_PRESSED;
          latched_code = code;
        end
      end
      DB_MAYBE_PRESSED: begin
        if (code == latched_code) begin
          db_state    = DB_STILL_PRESSED;
          r.confirmed = 1'b1;
          for (int k = 0; k < TABLE_SIZE; k++) begin
            if (!matched && CODE_TABLE[k] == latched_code) begin
              matched    = 1'b1;
              r.key_char = CHAR_TABLE[k];
              if (k == STAR_SLOT) begin
                held_digits = '0;
                r.cleared   = 1'b1;
              end else if (held_digits < BUFFER_DEPTH) begin
                r.position  = OUT_W'(held_digits);
                r.written   = 1'b1;
                held_digits = held_digits + 1'b1;
              end
            end
          end
        end else begin
          // A different code drops back without latching it
          db_state = DB_RELEASED;
        end
      end
      DB_STILL_PRESSED: begin
        if (code == '0) begin
          db_state = DB_MAYBE_RELEASED;
        end
      end
      default: begin
        db_state = (code != '0) ? DB_STILL_PRESSED : DB_RELEASED;
      end
    endcase
    r.state = db_state;
    r.count = OUT_W'(held_digits);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0d] %s: got 0x%0h, want 0x%0h", cycle_count, field, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    kdde_result_t want;
    // Check a result taken at this edge against the oldest forecast
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (debounce_state_o !== want.state)
          report_mismatch("debounce_state", 32'(debounce_state_o), 32'(want.state));
        if (key_confirmed_o !== want.confirmed)
          report_mismatch("key_confirmed", 32'(key_confirmed_o), 32'(want.confirmed));
        if (key_char_o !== want.key_char)
          report_mismatch("key_char", 32'(key_char_o), 32'(want.key_char));
        if (buffer_cleared_o !== want.cleared)
          report_mismatch("buffer_cleared", 32'(buffer_cleared_o), 32'(want.cleared));
        if (digit_written_o !== want.written)
          report_mismatch("digit_written", 32'(digit_written_o), 32'(want.written));
        if (write_position_o !== want.position)
          report_mismatch("write_position", 32'(write_position_o), 32'(want.position));
        if (digit_count_o !== want.count)
          report_mismatch("digit_count", 32'(digit_count_o), 32'(want.count));
      end
    end
    // Pick the stall for the next cycle; a hold-off request wins
    if (hold_off_seq != hold_off_seen) begin
      hold_off_seen = hold_off_seq;
      hold_off_left = hold_off_len;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= receiver_idles && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one scan tick, idle at random first, and forecast it once taken
  task automatic send_scan(input scan_t s);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    row1_columns_i <= s[0];
    row2_columns_i <= s[1];
    row3_columns_i <= s[2];
    row4_columns_i <= s[3];
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(step_keypad(s));
    scans_sent++;
  endtask

  // Scan tick that shows exactly one table key
  function automatic scan_t key_scan(input int unsigned slot);
    scan_t             s;
    logic [CODE_W-1:0] code;
    s    = '0;
    code = CODE_TABLE[slot];
    for (int r = 0; r < ROWS; r++) begin
      if (code[r]) s[r] = code[COL_SH +: COLS_W];
    end
    return s;
  endfunction

  function automatic scan_t noise_scan();
    scan_t s;
    for (int r = 0; r < ROWS; r++) begin
      s[r] = $urandom_range(1) ? COLS_W'($urandom_range(7)) : '0;
    end
    return s;
  endfunction

  // Press a scan for two ticks, then release it for two
  task automatic tap(input scan_t s);
    send_scan(s);
    send_scan(s);
    send_scan('0);
    send_scan('0);
  endtask

  task automatic wait_for_results();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // One random keypad gesture: mostly clean presses, some odd chords, some noise
  task automatic play_gesture();
    int unsigned kind;
    int unsigned slot;
    int unsigned row;
    scan_t       s;
    scan_t       held;
    bit          seen;
    kind = $urandom_range(99);
    if (kind < 75) begin
      // Keep '*' rare so the buffer often fills up
      if ($urandom_range(99) < 5) begin
        slot = 32'(STAR_SLOT);
      end else begin
        slot = $urandom_range(TABLE_SIZE - 2);
        if (slot >= STAR_SLOT) slot++;
      end
      s = key_scan(slot);
      if ($urandom_range(9) == 0) send_scan(noise_scan());
      repeat ($urandom_range(2, 4)) begin
        // Add ghost keys in later rows some of the time; the code stays put
        held = s;
        seen = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
          if (seen && $urandom_range(4) == 0) held[r] = COLS_W'($urandom_range(7));
          else if (held[r] != '0) seen = 1'b1;
        end
        send_scan(held);
      end
      if ($urandom_range(7) == 0) begin
        // Release bounce: the key flickers back once
        send_scan('0);
        send_scan(s);
      end
      repeat ($urandom_range(2, 3)) send_scan('0);
    end else if (kind < 85) begin
      // Several columns in one row: confirmed but never in the table
      s      = '0;
      row    = $urandom_range(ROWS - 1);
      s[row] = COLS_W'($urandom_range(1) ? 7 : (3 << $urandom_range(1)));
      if (s[row] == COLS_W'(6) && $urandom_range(1)) s[row] = COLS_W'(5);
      tap(s);
    end else begin
      repeat ($urandom_range(1, 6)) send_scan(noise_scan());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Drive all-zero and all-ones rows and a lone last row at full value
  task automatic test_field_extremes();
    scan_t s;
    send_scan('0);
    tap('1);
    s    = '0;
    s[3] = '1;
    tap(s);
  endtask

  // Cover ghost rows, a bounce to another key, '#' and '*'
  task automatic test_special_keys();
    scan_t s;
    s    = key_scan(5);
    s[2] = '1;
    s[3] = COLS_W'(5);
    tap(s);
    send_scan(key_scan(1));
    send_scan(key_scan(2));
    send_scan('0);
    tap(key_scan(TABLE_SIZE - 1));
    tap(key_scan(STAR_SLOT));
  endtask

  task automatic test_random_gestures(input int unsigned until_sent);
    while (scans_sent < until_sent) play_gesture();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming
  task automatic test_receiver_hold_off();
    int unsigned start;
    hold_off_len = 80;
    hold_off_seq++;
    start = scans_sent;
    while (scans_sent < start + 24) play_gesture();
  endtask

  // Run both sides with no idling at all
  task automatic test_full_rate_burst(input int unsigned count);
    int unsigned start;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    start          = scans_sent;
    while (scans_sent < start + count) play_gesture();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Pause the sender until every forecast result has come back
  task automatic test_sender_pause();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_for_results();
    repeat (6) play_gesture();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_special_keys();
    test_random_gestures(500);
    test_receiver_hold_off();
    test_full_rate_burst(200);
    test_sender_pause();
    test_random_gestures(ITEM_TARGET);

    // Drain outstanding results, then allow for the two-stage latency
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_for_results();
    repeat (6) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("keypad_debounce_digit_entry_core: match");
    end else begin
      $display("keypad_debounce_digit_entry_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
